// ===== rtl/cps_pkg.sv =====
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types, field widths and the color conversion for the palette block.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int CMD_W   = 2;
    localparam int CI_W    = 6;
    localparam int WORD_W  = 16;
    localparam int PI_W    = 8;
    localparam int COLOR_W = 15;
    localparam int RAW_W   = 9;   // three 3-bit channels kept from the raw word

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_REFRESH = 2'd1,
        CMD_LOOKUP  = 2'd2
    } t_cmd;

    // controller to datapath
    typedef struct packed {
        logic cap;
        logic cram_wr;
        logic walk_rd;
        logic addr_clr;
        logic bg_rd;
        logic copy_wr;
        logic lk_rd;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic addr_last;
        logic copy_last;
        logic bg_ok;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic [COLOR_W-1:0] normal;
        logic [COLOR_W-1:0] hilite;
        logic [COLOR_W-1:0] shadow;
    } t_conv;

    // Pack the used channel bits of a raw word: blue, green, red.
    function automatic logic [RAW_W-1:0] cps_pack(input logic [WORD_W-1:0] w);
        return {w[11:9], w[7:5], w[3:1]};
    endfunction

    // Normal is 4*v, shadow is 2*v, highlight is 2*v + 16 per channel.
    function automatic t_conv cps_conv(input logic [RAW_W-1:0] raw);
        t_conv res;
        logic [2:0] r;
        logic [2:0] g;
        logic [2:0] b;
        r = raw[2:0];
        g = raw[5:3];
        b = raw[8:6];
        res.normal = {b, 2'b00, g, 2'b00, r, 2'b00};
        res.shadow = {1'b0, b, 1'b0, 1'b0, g, 1'b0, 1'b0, r, 1'b0};
        res.hilite = {1'b1, b, 1'b0, 1'b1, g, 1'b0, 1'b1, r, 1'b0};
        return res;
    endfunction

endpackage

// ===== rtl/cps_ram.sv =====
// ----------------------------------------------------------------------------
// cps_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data between reads
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cps_ctrl.sv =====
// ----------------------------------------------------------------------------
// cps_ctrl
// Sequencer for write, refresh walk, background copy and lookup transactions.
// ----------------------------------------------------------------------------
module cps_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [cps_pkg::CMD_W-1:0] i_cmd,
    input  cps_pkg::t_dp_stat        i_stat,
    output cps_pkg::t_dp_cmd         o_dp_cmd,
    output logic                     o_busy
);
    import cps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH,
        S_BG_RD,
        S_BG_WR,
        S_LOOK
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd dp_cmd;

    always_comb begin
        dp_cmd  = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_WRITE: begin
                            dp_cmd.cram_wr = 1'b1;
                        end
                        CMD_REFRESH: begin
                            dp_cmd.cap      = 1'b1;
                            dp_cmd.addr_clr = 1'b1;
                            n_state         = S_WALK;
                        end
                        CMD_LOOKUP: begin
                            dp_cmd.lk_rd = 1'b1;
                            n_state      = S_LOOK;
                        end
                        default: begin
                            // unused code: drop the transaction
                        end
                    endcase
                end
            end
            S_WALK: begin
                dp_cmd.walk_rd = 1'b1;
                if (i_stat.addr_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // last conversion lands here; skip the copy for an out-of-range index
                if (i_stat.bg_ok) begin
                    dp_cmd.addr_clr = 1'b1;
                    n_state         = S_BG_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BG_RD: begin
                dp_cmd.bg_rd = 1'b1;
                n_state      = S_BG_WR;
            end
            S_BG_WR: begin
                dp_cmd.copy_wr = 1'b1;
                if (i_stat.copy_last) begin
                    n_state = S_IDLE;
                end
            end
            S_LOOK: begin
                if (i_stat.out_free) begin
                    dp_cmd.out_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_dp_cmd = dp_cmd;
    assign o_busy   = (r_state != S_IDLE);

endmodule

// ===== rtl/cps_dp.sv =====
// ----------------------------------------------------------------------------
// cps_dp
// Color RAM, dirty and valid flags, three palette banks and the output stage.
// ----------------------------------------------------------------------------
module cps_dp #(
    parameter int COLOR_COUNT = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cps_pkg::t_dp_cmd            i_dp_cmd,
    output cps_pkg::t_dp_stat           o_stat,
    input  logic [cps_pkg::CI_W-1:0]    i_cram_index,
    input  logic [cps_pkg::WORD_W-1:0]  i_cram_word,
    input  logic                        i_force_all,
    input  logic [cps_pkg::CI_W-1:0]    i_bg_index,
    input  logic [cps_pkg::PI_W-1:0]    i_pixel_index,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [cps_pkg::COLOR_W-1:0] o_color
);
    import cps_pkg::*;

    localparam int AW = $clog2(COLOR_COUNT);
    localparam int CW = AW + 1;

    typedef enum logic [1:0] {
        BANK_N,
        BANK_H,
        BANK_S,
        BANK_NONE
    } t_bank;

    // flags
    logic [COLOR_COUNT-1:0] r_dirty;
    logic [COLOR_COUNT-1:0] r_cvalid;   // color RAM entry written
    logic [COLOR_COUNT-1:0] r_nvalid;   // normal bank entry written
    logic [COLOR_COUNT-1:0] r_hvalid;   // highlight and shadow entries written

    logic [AW-1:0]   r_addr;
    logic            r_force;
    logic [CI_W-1:0] r_bg;
    logic            r_bg_live;

    logic            r_cv_pend;
    logic [AW-1:0]   r_cv_addr;
    logic            r_cv_live;

    t_bank           r_lk_bank;
    logic            r_lk_live;

    logic               r_out_vld;
    logic [COLOR_W-1:0] r_color;

    logic               wr_ok;
    logic [RAW_W-1:0]   cram_rdata;
    logic [RAW_W-1:0]   cram_val;
    t_conv              conv;
    logic [COLOR_W-1:0] n_rdata;
    logic [COLOR_W-1:0] h_rdata;
    logic [COLOR_W-1:0] s_rdata;
    logic [COLOR_W-1:0] bg_color;
    logic               n_we;
    logic [AW-1:0]      n_waddr;
    logic [COLOR_W-1:0] n_wdata;
    logic [AW-1:0]      rd_addr;
    t_bank              lk_bank;
    logic [PI_W-1:0]    lk_off;
    logic               lk_live;
    logic [COLOR_W-1:0] lk_color;
    logic [CW-1:0]      copy_next;

    assign wr_ok = ({1'b0, i_cram_index} < (CI_W + 1)'(COLOR_COUNT));

    cps_ram #(.WIDTH(RAW_W), .DEPTH(COLOR_COUNT)) u_cram (
        .i_clk   (i_clk),
        .i_we    (i_dp_cmd.cram_wr && wr_ok),
        .i_waddr (i_cram_index[AW-1:0]),
        .i_wdata (cps_pack(i_cram_word)),
        .i_re    (i_dp_cmd.walk_rd),
        .i_raddr (r_addr),
        .o_rdata (cram_rdata)
    );

    assign cram_val = r_cv_live ? cram_rdata : '0;
    assign conv     = cps_conv(cram_val);

    // normal bank write port is shared by conversion and background copy
    assign bg_color = r_bg_live ? n_rdata : '0;
    assign n_we     = r_cv_pend || i_dp_cmd.copy_wr;
    assign n_waddr  = i_dp_cmd.copy_wr ? r_addr : r_cv_addr;
    assign n_wdata  = i_dp_cmd.copy_wr ? bg_color : conv.normal;

    // lookup bank decode
    always_comb begin
        if (i_pixel_index < PI_W'(COLOR_COUNT)) begin
            lk_bank = BANK_N;
            lk_off  = i_pixel_index;
        end else if (i_pixel_index < PI_W'(2 * COLOR_COUNT)) begin
            lk_bank = BANK_H;
            lk_off  = i_pixel_index - PI_W'(COLOR_COUNT);
        end else if (i_pixel_index < PI_W'(3 * COLOR_COUNT)) begin
            lk_bank = BANK_S;
            lk_off  = i_pixel_index - PI_W'(2 * COLOR_COUNT);
        end else begin
            lk_bank = BANK_NONE;
            lk_off  = '0;
        end
    end

    always_comb begin
        unique case (lk_bank)
            BANK_N:    lk_live = r_nvalid[lk_off[AW-1:0]];
            BANK_H:    lk_live = r_hvalid[lk_off[AW-1:0]];
            BANK_S:    lk_live = r_hvalid[lk_off[AW-1:0]];
            BANK_NONE: lk_live = 1'b0;
            default:   lk_live = 1'b0;
        endcase
    end

    assign rd_addr = i_dp_cmd.lk_rd ? lk_off[AW-1:0] : r_bg[AW-1:0];

    cps_ram #(.WIDTH(COLOR_W), .DEPTH(COLOR_COUNT)) u_bank_n (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_re    (i_dp_cmd.lk_rd || i_dp_cmd.bg_rd),
        .i_raddr (rd_addr),
        .o_rdata (n_rdata)
    );

    cps_ram #(.WIDTH(COLOR_W), .DEPTH(COLOR_COUNT)) u_bank_h (
        .i_clk   (i_clk),
        .i_we    (r_cv_pend),
        .i_waddr (r_cv_addr),
        .i_wdata (conv.hilite),
        .i_re    (i_dp_cmd.lk_rd),
        .i_raddr (rd_addr),
        .o_rdata (h_rdata)
    );

    cps_ram #(.WIDTH(COLOR_W), .DEPTH(COLOR_COUNT)) u_bank_s (
        .i_clk   (i_clk),
        .i_we    (r_cv_pend),
        .i_waddr (r_cv_addr),
        .i_wdata (conv.shadow),
        .i_re    (i_dp_cmd.lk_rd),
        .i_raddr (rd_addr),
        .o_rdata (s_rdata)
    );

    always_comb begin
        unique case (r_lk_bank)
            BANK_N:    lk_color = n_rdata;
            BANK_H:    lk_color = h_rdata;
            BANK_S:    lk_color = s_rdata;
            BANK_NONE: lk_color = '0;
            default:   lk_color = '0;
        endcase
    end

    assign copy_next = {1'b0, r_addr} + CW'(16);

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty   <= '0;
            r_cvalid  <= '0;
            r_nvalid  <= '0;
            r_hvalid  <= '0;
            r_cv_pend <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_dp_cmd.cram_wr && wr_ok) begin
                r_dirty[i_cram_index[AW-1:0]]  <= 1'b1;
                r_cvalid[i_cram_index[AW-1:0]] <= 1'b1;
            end
            if (i_dp_cmd.walk_rd) begin
                r_dirty[r_addr] <= 1'b0;
            end
            r_cv_pend <= i_dp_cmd.walk_rd && (r_force || r_dirty[r_addr]);
            if (r_cv_pend) begin
                r_nvalid[r_cv_addr] <= 1'b1;
                r_hvalid[r_cv_addr] <= 1'b1;
            end
            if (i_dp_cmd.copy_wr) begin
                r_nvalid[r_addr] <= 1'b1;
            end
            if (i_dp_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload and address registers
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.cap) begin
            r_force <= i_force_all;
            r_bg    <= i_bg_index;
        end
        if (i_dp_cmd.addr_clr) begin
            r_addr <= '0;
        end else if (i_dp_cmd.walk_rd) begin
            r_addr <= r_addr + AW'(1);
        end else if (i_dp_cmd.copy_wr) begin
            r_addr <= copy_next[AW-1:0];
        end
        if (i_dp_cmd.walk_rd) begin
            r_cv_addr <= r_addr;
            r_cv_live <= r_cvalid[r_addr];
        end
        if (i_dp_cmd.bg_rd) begin
            r_bg_live <= r_nvalid[r_bg[AW-1:0]];
        end
        if (i_dp_cmd.lk_rd) begin
            r_lk_bank <= lk_bank;
            r_lk_live <= lk_live;
        end
        if (i_dp_cmd.out_load) begin
            r_color <= r_lk_live ? lk_color : '0;
        end
    end

    assign o_stat.addr_last = (r_addr == AW'(COLOR_COUNT - 1));
    assign o_stat.copy_last = (copy_next >= CW'(COLOR_COUNT));
    assign o_stat.bg_ok     = ({1'b0, r_bg} < (CI_W + 1)'(COLOR_COUNT));
    assign o_stat.out_free  = !r_out_vld || !i_stall;

    assign o_valid = r_out_vld;
    assign o_color = r_color;

endmodule

// ===== rtl/cram_palette_shadow_highlight.sv =====
// ----------------------------------------------------------------------------
// cram_palette_shadow_highlight
// Color RAM store with an RGB555 normal/highlight/shadow palette cache.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries one command per transaction:
// a color RAM write, a palette refresh or a palette lookup. The output
// channel (o_valid / i_stall) returns one color per lookup only.
//
// Write: the next transaction may follow at once.
// Lookup: the palette banks are read into their registered outputs on accept;
//   the color is then loaded into the output register from the lookup state,
//   which holds off the input, so a new lookup is taken only after the last
//   one has left that state, set by the registered read of the palette banks.
// Refresh: the input is held off while the sequencer walks the color RAM
//   one entry a cycle and then passes a flush state, and further, when the
//   background index is in range, while it reads the background entry and
//   copies it into the normal entries at multiples of 16.
// Reset clears all flags, so every store reads as zero until written; no
//   clearing pass is run. A color stalled in the output register does not
//   hold off the input by itself; a following lookup waits in its read
//   stage, holding off the input channel, until the stalled color is taken.
// ----------------------------------------------------------------------------
module cram_palette_shadow_highlight #(
    parameter int COLOR_COUNT = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [cps_pkg::CMD_W-1:0]   i_cmd,
    input  logic [cps_pkg::CI_W-1:0]    i_cram_index,
    input  logic [cps_pkg::WORD_W-1:0]  i_cram_word,
    input  logic                        i_force_all,
    input  logic [cps_pkg::CI_W-1:0]    i_bg_index,
    input  logic [cps_pkg::PI_W-1:0]    i_pixel_index,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [cps_pkg::COLOR_W-1:0] o_color
);
    import cps_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    cps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cmd    (i_cmd),
        .i_stat   (dp_stat),
        .o_dp_cmd (dp_cmd),
        .o_busy   (o_stall)
    );

    cps_dp #(.COLOR_COUNT(COLOR_COUNT)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (dp_cmd),
        .o_stat        (dp_stat),
        .i_cram_index  (i_cram_index),
        .i_cram_word   (i_cram_word),
        .i_force_all   (i_force_all),
        .i_bg_index    (i_bg_index),
        .i_pixel_index (i_pixel_index),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_color       (o_color)
    );

endmodule

// ===== rtl/cps_chk.sv =====
// ----------------------------------------------------------------------------
// cps_chk
// Port-level checks for the palette block, bound to the top level.
// ----------------------------------------------------------------------------
module cps_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic [cps_pkg::CMD_W-1:0] i_cmd,
    input logic                      o_valid,
    input logic                      i_stall
);
    import cps_pkg::*;

    logic in_acc;
    assign in_acc = i_valid && !o_stall;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // a lookup transaction holds off the input for its read cycle
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_cmd == CMD_LOOKUP) |=> o_stall)
        else $error("input not held after lookup");

    // a refresh transaction starts the walk
    a_refresh_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_cmd == CMD_REFRESH) |=> o_stall)
        else $error("input not held after refresh");

    // a write does not hold off the input after it is taken
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_cmd == CMD_WRITE) |=> !o_stall)
        else $error("write held off the input");

    // a new result only follows lookup work in the sequencer
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without lookup");

endmodule

bind cram_palette_shadow_highlight cps_chk u_cps_chk (.*);

// ===== bench/cram_palette_shadow_highlight_test.sv =====
// ----------------------------------------------------------------------------
// cram_palette_shadow_highlight_test
// Self-checking bench for the color RAM palette cache: a scoreboard mirrors the
// color RAM, its dirty flags and the normal/highlight/shadow cache, predicts
// every lookup color and compares it with the block's output, under random
// idle gaps and back-pressure on both channels.
// ----------------------------------------------------------------------------
module cram_palette_shadow_highlight_test;
    import cps_pkg::*;

    localparam int COLORS      = 64;
    localparam int CACHE_DEPTH = 3 * COLORS;
    localparam int ITEM_TARGET = 1750;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 100;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow copy of the block state and the queue of colors due
    // ------------------------------------------------------------------------
    class palette_scoreboard;
        logic [11:0]        cram_q [COLORS];
        bit                 dirty_q [COLORS];
        logic [COLOR_W-1:0] cache_q [CACHE_DEPTH];
        logic [COLOR_W-1:0] colors_due [$];
        int                 errors;
        int                 checked;

        function new();
            foreach (cram_q[i]) begin
                cram_q[i]  = '0;
                dirty_q[i] = 1'b0;
            end
            foreach (cache_q[i]) cache_q[i] = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function logic [COLOR_W-1:0] rgb555(input logic [4:0] r, input logic [4:0] g,
                                            input logic [4:0] b);
            return {b, g, r};
        endfunction

        function void convert_entry(input int idx);
            logic [2:0] r;
            logic [2:0] g;
            logic [2:0] b;
            r = cram_q[idx][3:1];
            g = cram_q[idx][7:5];
            b = cram_q[idx][11:9];
            cache_q[idx]              = rgb555(5'(4 * r), 5'(4 * g), 5'(4 * b));
            cache_q[idx + COLORS]     = rgb555(5'(2 * r + 16), 5'(2 * g + 16), 5'(2 * b + 16));
            cache_q[idx + 2 * COLORS] = rgb555(5'(2 * r), 5'(2 * g), 5'(2 * b));
        endfunction

        function void note_input(input logic [CMD_W-1:0] cmd, input logic [CI_W-1:0] ci,
                                 input logic [WORD_W-1:0] word, input logic frc,
                                 input logic [CI_W-1:0] bg, input logic [PI_W-1:0] pi);
            logic [COLOR_W-1:0] bg_color;
            if (cmd == CMD_WRITE) begin
                if (int'(ci) < COLORS) begin
                    cram_q[ci]  = word[11:0];
                    dirty_q[ci] = 1'b1;
                end
            end else if (cmd == CMD_REFRESH) begin
                for (int i = 0; i < COLORS; i++) begin
                    if (frc || dirty_q[i]) begin
                        dirty_q[i] = 1'b0;
                        convert_entry(i);
                    end
                end
                // background overwrites the normal entries at multiples of 16
                if (int'(bg) < COLORS) begin
                    bg_color = cache_q[bg];
                    for (int i = 0; i < COLORS; i += 16) cache_q[i] = bg_color;
                end
            end else if (cmd == CMD_LOOKUP) begin
                colors_due.push_back(int'(pi) < CACHE_DEPTH ? cache_q[pi] : '0);
            end
        endfunction

        function int pending();
            return colors_due.size();
        endfunction

        task report(input string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_color(input logic [COLOR_W-1:0] got);
            logic [COLOR_W-1:0] want;
            if (colors_due.size() == 0) begin
                report($sformatf("color %h with no lookup pending", got));
            end else begin
                want = colors_due.pop_front();
                checked++;
                if (got !== want)
                    report($sformatf("lookup %0d: color %h, expected %h", checked, got, want));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and clocking
    // ------------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [CMD_W-1:0]   i_cmd;
    logic [CI_W-1:0]    i_cram_index;
    logic [WORD_W-1:0]  i_cram_word;
    logic               i_force_all;
    logic [CI_W-1:0]    i_bg_index;
    logic [PI_W-1:0]    i_pixel_index;
    logic               o_valid;
    logic               i_stall;
    logic [COLOR_W-1:0] o_color;

    cram_palette_shadow_highlight #(.COLOR_COUNT(COLORS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_cram_index  (i_cram_index),
        .i_cram_word   (i_cram_word),
        .i_force_all   (i_force_all),
        .i_bg_index    (i_bg_index),
        .i_pixel_index (i_pixel_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_color       (o_color)
    );

    palette_scoreboard sb = new();

    int n_items;
    int n_writes;
    int n_refreshes;
    int n_lookups;
    int n_ignored;
    int tx_calm_left;
    int rx_left;
    int idle_cycles;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    function int pick_gap();
        int r;
        if (tx_calm_left > 0) begin
            tx_calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            tx_calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [CI_W-1:0] ci,
                            input logic [WORD_W-1:0] word, input logic frc,
                            input logic [CI_W-1:0] bg, input logic [PI_W-1:0] pi);
        int gap;
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_cram_index  <= ci;
        i_cram_word   <= word;
        i_force_all   <= frc;
        i_bg_index    <= bg;
        i_pixel_index <= pi;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(cmd, ci, word, frc, bg, pi);
        if (cmd == CMD_WRITE) n_writes++;
        else if (cmd == CMD_REFRESH) n_refreshes++;
        else if (cmd == CMD_LOOKUP) n_lookups++;
        if (cmd == CMD_UNUSED) n_ignored++;
        else n_items++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic do_write(input logic [CI_W-1:0] ci, input logic [WORD_W-1:0] word);
        send_cmd(CMD_WRITE, ci, word, 1'($urandom), 6'($urandom), 8'($urandom));
    endtask

    task automatic do_refresh(input logic frc, input logic [CI_W-1:0] bg);
        send_cmd(CMD_REFRESH, 6'($urandom), 16'($urandom), frc, bg, 8'($urandom));
    endtask

    task automatic do_lookup(input logic [PI_W-1:0] pi);
        send_cmd(CMD_LOOKUP, 6'($urandom), 16'($urandom), 1'($urandom), 6'($urandom), pi);
    endtask

    function logic [PI_W-1:0] rand_pixel();
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(CACHE_DEPTH, 255));
        return 8'($urandom_range(0, CACHE_DEPTH - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Output side: check accepted colors, then pick the next stall value
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_color(o_color);
        if (rx_left > 0) begin
            rx_left--;
        end else begin
            case ($urandom_range(0, 9))
                0: begin
                    i_stall <= 1'b0;
                    rx_left = $urandom_range(50, 200);
                end
                1: begin
                    i_stall <= 1'b1;
                    rx_left = $urandom_range(15, 40);
                end
                2, 3, 4, 5: begin
                    i_stall <= 1'b1;
                    rx_left = $urandom_range(0, 3);
                end
                default: begin
                    i_stall <= 1'b0;
                    rx_left = $urandom_range(0, 8);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no transaction moves for too long
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d colors due",
                         IDLE_LIMIT, sb.pending());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int  n_wr;
        int  n_lk;
        bit  paused;
        n_items      = 0;
        n_writes     = 0;
        n_refreshes  = 0;
        n_lookups    = 0;
        n_ignored    = 0;
        tx_calm_left = 0;
        rx_left      = 0;
        idle_cycles  = 0;
        paused       = 1'b0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_stall       <= 1'b0;
        i_cmd         <= CMD_WRITE;
        i_cram_index  <= '0;
        i_cram_word   <= '0;
        i_force_all   <= 1'b0;
        i_bg_index    <= '0;
        i_pixel_index <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cache reads zero straight out of reset, in range or not
        do_lookup(8'd0);
        do_lookup(8'd191);
        do_lookup(8'd192);
        do_lookup(8'd255);
        // full-scale, zero, all channels set, unused bits only, alternating
        do_write(6'd0, 16'hFFFF);
        do_write(6'd63, 16'h0000);
        do_write(6'd5, 16'h0EEE);
        do_write(6'd16, 16'hF111);
        do_write(6'd17, 16'h0AAA);
        send_cmd(CMD_UNUSED, 6'd5, 16'h0000, 1'b1, 6'd0, 8'd5);
        do_refresh(1'b0, 6'd5);
        do_lookup(8'd0);
        do_lookup(8'd5);
        do_lookup(8'd16);
        do_lookup(8'd17);
        do_lookup(8'd69);
        do_lookup(8'd133);
        do_lookup(8'd191);
        // forced refresh with the last entry as background
        do_refresh(1'b1, 6'd63);
        do_lookup(8'd0);
        do_lookup(8'd32);
        do_lookup(8'd64);
        do_lookup(8'd128);

        while (n_items < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 8) begin
                n_wr = $urandom_range(1, 8);
                repeat (n_wr) do_write(6'($urandom), 16'($urandom));
                do_refresh($urandom_range(0, 3) == 0, 6'($urandom));
                n_lk = $urandom_range(2, 10);
                repeat (n_lk) do_lookup(rand_pixel());
            end else begin
                repeat ($urandom_range(1, 6))
                    send_cmd(2'($urandom), 6'($urandom), 16'($urandom), 1'($urandom),
                             6'($urandom), rand_pixel());
            end
            // hold the input until every due color has come back
            if (!paused && n_items >= ITEM_TARGET / 2) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d writes, %0d refreshes, %0d lookups, %0d unused commands",
                 n_writes, n_refreshes, n_lookups, n_ignored);
        $display("%0d colors compared, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== cram_palette_shadow_highlight.f =====
rtl/cps_pkg.sv
rtl/cps_ram.sv
rtl/cps_ctrl.sv
rtl/cps_dp.sv
rtl/cram_palette_shadow_highlight.sv
rtl/cps_chk.sv
bench/cram_palette_shadow_highlight_test.sv
